>>> hw/rtl/bcc_pkg.sv
// Shared types, codes and reset values for the button click classifier.
package bcc_pkg;

  localparam int unsigned CFG_DATA_W  = 20;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned TICK_W      = 32;
  localparam int unsigned WINDOW_W    = 16;
  localparam int unsigned STUCK_W     = 20;

  localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_LOW    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DOUBLE_WINDOW = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LONG_LIMIT    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_GLITCH        = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_STUCK         = 3'd4;

  localparam logic                RST_ACTIVE_LOW    = 1'b1;
  localparam logic [WINDOW_W-1:0] RST_DOUBLE_WINDOW = 16'd200;
  localparam logic [WINDOW_W-1:0] RST_LONG_LIMIT    = 16'd700;
  localparam logic [WINDOW_W-1:0] RST_GLITCH        = 16'd15;
  localparam logic [STUCK_W-1:0]  RST_STUCK         = 20'd10000;

  typedef logic [1:0] click_event_t;
  localparam click_event_t EV_NONE   = 2'd0;
  localparam click_event_t EV_SHORT  = 2'd1;
  localparam click_event_t EV_LONG   = 2'd2;
  localparam click_event_t EV_DOUBLE = 2'd3;

  typedef logic [2:0] state_code_t;
  localparam state_code_t ST_IDLE     = 3'd0;
  localparam state_code_t ST_PRESSED  = 3'd1;
  localparam state_code_t ST_RELEASED = 3'd2;
  localparam state_code_t ST_SHORT    = 3'd3;
  localparam state_code_t ST_LONG     = 3'd4;
  localparam state_code_t ST_DOUBLE   = 3'd5;
  localparam state_code_t ST_WAIT     = 3'd6;

  typedef enum logic [6:0] {
    PH_IDLE     = 7'b0000001,
    PH_PRESSED  = 7'b0000010,
    PH_RELEASED = 7'b0000100,
    PH_SHORT    = 7'b0001000,
    PH_LONG     = 7'b0010000,
    PH_DOUBLE   = 7'b0100000,
    PH_WAIT     = 7'b1000000
  } phase_t;

  function automatic state_code_t phase_code(input phase_t ph);
    state_code_t code;
    unique case (ph)
      PH_PRESSED:  code = ST_PRESSED;
      PH_RELEASED: code = ST_RELEASED;
      PH_SHORT:    code = ST_SHORT;
      PH_LONG:     code = ST_LONG;
      PH_DOUBLE:   code = ST_DOUBLE;
      PH_WAIT:     code = ST_WAIT;
      default:     code = ST_IDLE;
    endcase
    return code;
  endfunction

endpackage

>>> hw/rtl/bcc_if.sv
// Valid/ready channel interfaces for button polls and classifier results.
interface bcc_in_if
  import bcc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              pin_level;
  logic [TICK_W-1:0] now_ticks;

  modport source (output valid, output pin_level, output now_ticks, input ready);
  modport sink   (input valid, input pin_level, input now_ticks, output ready);
endinterface

interface bcc_out_if
  import bcc_pkg::*;
();
  logic         valid;
  logic         ready;
  click_event_t click_event;
  state_code_t  fsm_state;

  modport source (output valid, output click_event, output fsm_state, input ready);
  modport sink   (input valid, input click_event, input fsm_state, output ready);
endinterface

>>> hw/rtl/button_click_classifier_unit.sv
// Button click classifier: polled pin in, short/long/double click events out.
//
// The poll channel carries one item per sample: the raw pin level and a
// free-running 32-bit tick stamp. The result channel returns exactly one
// item per poll: the click event (none, short, long, double) and the
// classifier state after that poll. The user must write configuration
// registers via a simple write port while no poll is in flight (unenforced).
//
// Each poll is captured in an input register and classified into the
// result register once that register is free. One poll is accepted per
// cycle while the result receiver keeps up; the limit is the state machine
// update, which steps once per poll.
//
// When the result receiver stalls, the result register holds its item and
// the input register still takes one more poll; after that the poll channel
// deasserts ready until the result is taken.
//
// Reset empties both registers, returns the state machine to idle, clears
// both timestamps and loads the default configuration.
module button_click_classifier_unit
  import bcc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  bcc_in_if.sink                 poll,
  bcc_out_if.source              result
);

  logic                active_low;
  logic [WINDOW_W-1:0] double_window;
  logic [WINDOW_W-1:0] long_limit;
  logic [WINDOW_W-1:0] glitch;
  logic [STUCK_W-1:0]  stuck;

  logic                s1_valid;
  logic                s1_pin;
  logic [TICK_W-1:0]   s1_now;

  logic                out_valid;
  click_event_t        out_event;
  state_code_t         out_state;

  phase_t              phase, phase_next;
  logic [TICK_W-1:0]   press_stamp, press_stamp_next;
  logic [TICK_W-1:0]   release_stamp, release_stamp_next;
  click_event_t        event_next;

  logic                out_free;
  logic                advance;
  logic                pressed;
  logic [TICK_W-1:0]   since_press, since_release, held;

  assign out_free   = !out_valid || result.ready;
  assign advance    = s1_valid && out_free;
  assign poll.ready = !s1_valid || out_free;

  assign result.valid       = out_valid;
  assign result.click_event = out_event;
  assign result.fsm_state   = out_state;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_low    <= RST_ACTIVE_LOW;
      double_window <= RST_DOUBLE_WINDOW;
      long_limit    <= RST_LONG_LIMIT;
      glitch        <= RST_GLITCH;
      stuck         <= RST_STUCK;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ACTIVE_LOW:    active_low    <= cfg_data[0];
        CFG_DOUBLE_WINDOW: double_window <= cfg_data[WINDOW_W-1:0];
        CFG_LONG_LIMIT:    long_limit    <= cfg_data[WINDOW_W-1:0];
        CFG_GLITCH:        glitch        <= cfg_data[WINDOW_W-1:0];
        CFG_STUCK:         stuck         <= cfg_data[STUCK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (poll.ready) begin
      s1_valid <= poll.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll.valid && poll.ready) begin
      s1_pin <= poll.pin_level;
      s1_now <= poll.now_ticks;
    end
  end

  // With active_low set, a low pin is a press; otherwise a high pin is.
  assign pressed       = (s1_pin == !active_low);
  assign since_press   = s1_now - press_stamp;
  assign since_release = s1_now - release_stamp;
  assign held          = release_stamp - press_stamp;

  always_comb begin
    phase_next         = phase;
    press_stamp_next   = press_stamp;
    release_stamp_next = release_stamp;
    event_next         = EV_NONE;
    unique case (phase)
      PH_PRESSED: begin
        if (!pressed) begin
          release_stamp_next = s1_now;
          phase_next         = PH_RELEASED;
        end else if (since_press > TICK_W'(long_limit)) begin
          phase_next = PH_LONG;
        end else if (since_press > TICK_W'(stuck)) begin
          phase_next = PH_IDLE;
        end
      end
      PH_RELEASED: begin
        if (pressed && since_release < TICK_W'(double_window)) begin
          phase_next = PH_DOUBLE;
        end else if (held > TICK_W'(glitch) && since_release > TICK_W'(double_window)) begin
          phase_next = PH_SHORT;
        end else if (since_release > TICK_W'(stuck)) begin
          phase_next = PH_IDLE;
        end
      end
      PH_SHORT: begin
        event_next = EV_SHORT;
        phase_next = PH_WAIT;
      end
      PH_LONG: begin
        event_next = EV_LONG;
        phase_next = PH_WAIT;
      end
      PH_DOUBLE: begin
        event_next = EV_DOUBLE;
        phase_next = PH_WAIT;
      end
      PH_WAIT: begin
        if (!pressed) begin
          phase_next = PH_IDLE;
        end
      end
      default: begin
        if (pressed) begin
          phase_next       = PH_PRESSED;
          press_stamp_next = s1_now;
        end else begin
          phase_next = PH_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      press_stamp   <= '0;
      release_stamp <= '0;
    end else if (advance) begin
      phase         <= phase_next;
      press_stamp   <= press_stamp_next;
      release_stamp <= release_stamp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_event <= event_next;
      out_state <= phase_code(phase_next);
    end
  end

endmodule

>>> hw/rtl/bcc_checker.sv
// Port-level assertions for the button click classifier, bound to the top level.
module bcc_checker
  import bcc_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         out_valid,
  input logic         out_ready,
  input click_event_t click_event,
  input state_code_t  fsm_state
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_event_then_wait: assert property (@(posedge clk) disable iff (rst)
    (out_valid && click_event != EV_NONE) |-> fsm_state == ST_WAIT)
    else $error("click event reported outside the wait-release state");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("stalled result dropped");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(click_event) && $stable(fsm_state)))
    else $error("stalled result changed");

endmodule

bind button_click_classifier_unit bcc_checker u_bcc_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .click_event (result.click_event),
  .fsm_state   (result.fsm_state)
);

>>> test/bcc_click_checker.sv
// Checker that predicts every classifier result from the accepted polls and compares it.
module bcc_click_checker
  import bcc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  bcc_in_if                      poll,
  bcc_out_if                     result,
  output int                     fail_count,
  output int                     outstanding
);

  typedef struct packed {
    click_event_t click;
    state_code_t  state;
  } click_result_t;

  click_result_t expected_clicks[$];
  click_result_t want;
  click_result_t seen;

  logic                active_low;
  logic [WINDOW_W-1:0] double_window;
  logic [WINDOW_W-1:0] long_limit;
  logic [WINDOW_W-1:0] glitch_len;
  logic [STUCK_W-1:0]  stuck_len;

  state_code_t       phase;
  logic [TICK_W-1:0] press_stamp;
  logic [TICK_W-1:0] release_stamp;

  int errors = 0;

  assign fail_count = errors;

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 100) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  task automatic classify_poll(input logic pin, input logic [TICK_W-1:0] stamp,
                               output click_result_t res);
    logic              held_down;
    logic [TICK_W-1:0] since_press;
    logic [TICK_W-1:0] since_release;
    logic [TICK_W-1:0] held;
    held_down     = pin ^ active_low;
    since_press   = stamp - press_stamp;
    since_release = stamp - release_stamp;
    held          = release_stamp - press_stamp;
    res.click     = EV_NONE;
    case (phase)
      ST_PRESSED: begin
        if (!held_down) begin
          release_stamp = stamp;
          phase = ST_RELEASED;
        end else if (since_press > long_limit) begin
          phase = ST_LONG;
        end else if (since_press > stuck_len) begin
          phase = ST_IDLE;
        end
      end
      ST_RELEASED: begin
        if (held_down && since_release < double_window) begin
          phase = ST_DOUBLE;
        end else if (held > glitch_len && since_release > double_window) begin
          phase = ST_SHORT;
        end else if (since_release > stuck_len) begin
          phase = ST_IDLE;
        end
      end
      ST_SHORT: begin
        res.click = EV_SHORT;
        phase = ST_WAIT;
      end
      ST_LONG: begin
        res.click = EV_LONG;
        phase = ST_WAIT;
      end
      ST_DOUBLE: begin
        res.click = EV_DOUBLE;
        phase = ST_WAIT;
      end
      ST_WAIT: begin
        if (!held_down) phase = ST_IDLE;
      end
      default: begin
        if (held_down) begin
          phase = ST_PRESSED;
          press_stamp = stamp;
        end else begin
          phase = ST_IDLE;
        end
      end
    endcase
    res.state = phase;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      active_low    = RST_ACTIVE_LOW;
      double_window = RST_DOUBLE_WINDOW;
      long_limit    = RST_LONG_LIMIT;
      glitch_len    = RST_GLITCH;
      stuck_len     = RST_STUCK;
      phase         = ST_IDLE;
      press_stamp   = '0;
      release_stamp = '0;
      expected_clicks.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_ACTIVE_LOW:    active_low = cfg_data[0];
          CFG_DOUBLE_WINDOW: double_window = cfg_data[WINDOW_W-1:0];
          CFG_LONG_LIMIT:    long_limit = cfg_data[WINDOW_W-1:0];
          CFG_GLITCH:        glitch_len = cfg_data[WINDOW_W-1:0];
          CFG_STUCK:         stuck_len = cfg_data[STUCK_W-1:0];
          default: ;
        endcase
      end
      if (result.valid === 1'b1 && result.ready === 1'b1) begin
        seen.click = result.click_event;
        seen.state = result.fsm_state;
        if (expected_clicks.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: event %0d state %0d",
                                    seen.click, seen.state));
        end else begin
          want = expected_clicks.pop_front();
          if (seen.click !== want.click) begin
            report_mismatch($sformatf("click_event mismatch: expected %0d, got %0d",
                                      want.click, seen.click));
          end
          if (seen.state !== want.state) begin
            report_mismatch($sformatf("fsm_state mismatch: expected %0d, got %0d",
                                      want.state, seen.state));
          end
        end
      end
      if (poll.valid === 1'b1 && poll.ready === 1'b1) begin
        classify_poll(poll.pin_level, poll.now_ticks, want);
        expected_clicks.push_back(want);
      end
    end
    outstanding <= expected_clicks.size();
  end

endmodule

>>> test/button_click_classifier_unit_test.sv
// Stimulus, handshake idling and final verdict for the button click classifier unit.
module button_click_classifier_unit_test;
  import bcc_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  bcc_in_if  poll();
  bcc_out_if result();

  int fail_count;
  int outstanding;

  // Pin level that means pressed, and the current thresholds, as last written.
  logic              down_level;
  int                win_ticks;
  int                long_ticks;
  int                glitch_ticks;
  int                stuck_ticks;
  logic [TICK_W-1:0] tnow;
  int                polls_sent = 0;
  logic              calm = 1'b1;
  int                stall_left = 0;

  button_click_classifier_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .poll      (poll),
    .result    (result)
  );

  bcc_click_checker click_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .poll        (poll),
    .result      (result),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #8000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int span(input int lo, input int hi);
    if (hi <= lo) return lo;
    return $urandom_range(lo, hi);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      result.ready <= 1'b0;
    end else begin
      stall_left = pick_gap();
      result.ready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  task automatic send_poll(input logic pin, input logic [TICK_W-1:0] stamp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      poll.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    poll.valid     <= 1'b1;
    poll.pin_level <= pin;
    poll.now_ticks <= stamp;
    @(posedge clk);
    while (poll.ready !== 1'b1) @(posedge clk);
    polls_sent++;
  endtask

  task automatic settle();
    poll.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_field(input logic [CFG_INDEX_W-1:0] idx, input int value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
  endtask

  task automatic load_settings(input logic al, input int win, input int lng,
                               input int gl, input int st);
    write_field(CFG_ACTIVE_LOW, int'(al));
    write_field(CFG_DOUBLE_WINDOW, win);
    write_field(CFG_LONG_LIMIT, lng);
    write_field(CFG_GLITCH, gl);
    write_field(CFG_STUCK, st);
    cfg_write <= 1'b0;
    @(posedge clk);
    down_level   = !al;
    win_ticks    = win;
    long_ticks   = lng;
    glitch_ticks = gl;
    stuck_ticks  = st;
  endtask

  // Holds the pin at one level for somewhat more than the given number of ticks.
  task automatic hold_pin(input logic pin, input int dur);
    int elapsed;
    int advance;
    elapsed = 0;
    do begin
      send_poll(pin, tnow);
      advance = $urandom_range(0, dur / 4 + 1);
      tnow += TICK_W'(advance);
      elapsed += advance;
    end while (elapsed <= dur);
  endtask

  task automatic play_episode();
    int kind;
    int n;
    calm <= ($urandom_range(0, 4) == 0);
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1: begin
        hold_pin(down_level, span(glitch_ticks + 1, long_ticks));
        hold_pin(!down_level, span(win_ticks + 1, win_ticks + win_ticks / 2 + 50));
      end
      2, 3: begin
        hold_pin(down_level, span(long_ticks + 1, long_ticks + long_ticks / 2 + 50));
      end
      4, 5: begin
        hold_pin(down_level, span(glitch_ticks + 1, long_ticks));
        hold_pin(!down_level, span(0, win_ticks));
        hold_pin(down_level, span(0, long_ticks));
      end
      6: begin
        hold_pin(down_level, span(0, glitch_ticks));
        hold_pin(!down_level, span(0, stuck_ticks + stuck_ticks / 4 + 20));
      end
      7: begin
        hold_pin(down_level, span(0, glitch_ticks));
        hold_pin(!down_level, span(win_ticks, win_ticks + 50));
        hold_pin(down_level, span(0, stuck_ticks + 100));
      end
      8: begin
        hold_pin(down_level, span(0, (long_ticks > stuck_ticks ? long_ticks : stuck_ticks) + 100));
      end
      default: begin
        n = $urandom_range(4, 12);
        repeat (n) begin
          send_poll(1'($urandom_range(0, 1)), tnow);
          if ($urandom_range(0, 3) == 0) tnow = $urandom();
          else tnow += TICK_W'($urandom_range(0, 50));
        end
      end
    endcase
    hold_pin(!down_level, span(0, 3 * win_ticks + 30));
  endtask

  task automatic run_random(input int count);
    int stop;
    stop = polls_sent + count;
    tnow = $urandom();
    while (polls_sent < stop) play_episode();
  endtask

  task automatic run_directed();
    send_poll(1'b1, 32'd0);
    send_poll(1'b0, 32'd100);
    send_poll(1'b0, 32'd800);
    send_poll(1'b0, 32'd801);
    send_poll(1'b0, 32'd802);
    send_poll(1'b0, 32'd900);
    send_poll(1'b1, 32'd901);
    send_poll(1'b0, 32'hFFFF_FFF0);
    send_poll(1'b1, 32'h0000_0000);
    send_poll(1'b1, 32'd200);
    send_poll(1'b1, 32'd201);
    send_poll(1'b1, 32'd202);
    send_poll(1'b1, 32'd203);
    send_poll(1'b0, 32'd1000);
    send_poll(1'b1, 32'd1015);
    send_poll(1'b0, 32'd1215);
    send_poll(1'b0, 32'd1214);
    send_poll(1'b0, 32'd1300);
    send_poll(1'b1, 32'd1301);
    send_poll(1'b0, 32'd2000);
    send_poll(1'b1, 32'd2005);
    send_poll(1'b1, 32'd12005);
    send_poll(1'b1, 32'd12006);
  endtask

  initial begin
    rst            = 1'b1;
    cfg_write      = 1'b0;
    cfg_index      = CFG_ACTIVE_LOW;
    cfg_data       = '0;
    poll.valid     = 1'b0;
    poll.pin_level = 1'b1;
    poll.now_ticks = '0;
    result.ready   = 1'b0;
    down_level     = !RST_ACTIVE_LOW;
    win_ticks      = int'(RST_DOUBLE_WINDOW);
    long_ticks     = int'(RST_LONG_LIMIT);
    glitch_ticks   = int'(RST_GLITCH);
    stuck_ticks    = int'(RST_STUCK);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    run_random(150);
    settle();

    load_settings(1'b0, 0, 0, 0, 0);
    run_random(150);
    settle();

    load_settings(1'b1, 65535, 65535, 65535, 1048575);
    run_random(150);
    settle();

    // The stuck timeout can only fire while pressed when it is below the long-press time.
    load_settings(1'b0, 300, 2000, 40, 500);
    run_random(150);
    settle();

    load_settings(1'b1, 0, 65535, 0, 3);
    run_random(150);
    settle();

    repeat (2) begin
      load_settings(1'($urandom_range(0, 1)), $urandom_range(0, 1000),
                    $urandom_range(0, 3000), $urandom_range(0, 200),
                    $urandom_range(0, 20000));
      run_random(150);
      settle();
    end

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/bcc_pkg.sv
hw/rtl/bcc_if.sv
hw/rtl/button_click_classifier_unit.sv
hw/rtl/bcc_checker.sv
test/bcc_click_checker.sv
test/button_click_classifier_unit_test.sv
